FILE: rtl/iir_direct_form_one_filter_core_assert.svh
// Assertion macros used by the filter controller.
`ifndef IIR_DIRECT_FORM_ONE_FILTER_CORE_ASSERT_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge while reset is released.
`define IIRDF1_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define IIRDF1_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define IIRDF1_ASSERT(name, prop, msg)
`define IIRDF1_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

FILE: rtl/iirdf1_pkg.sv
package iirdf1_pkg;

  // Fixed field widths.
  localparam int unsigned COEF_W     = 24;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned ORDER_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Parameter defaults.
  localparam int unsigned DEF_MAX_ORDER      = 4;
  localparam int unsigned DEF_SAMPLE_WIDTH   = 16;
  localparam int unsigned DEF_COEF_FRAC_BITS = 20;

  // Request commands.
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_FF  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WR_FB  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_IN_USE  = 2'd1;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_x;  // capture the incoming sample
    logic wr_ff;   // write a feedforward coefficient from the request
    logic wr_fb;   // write a feedback coefficient from the request
    logic mac_en;  // issue one product this cycle
    logic first;   // the issued product starts a new sum
    logic sel_fb;  // the issued product is a feedback term
    logic commit;  // load the output register and, unless pass is set, update the histories
    logic pass;    // the committed result is the bypassed sample
  } iirdf1_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } iirdf1_sts_t;

endpackage

FILE: rtl/iirdf1_if.sv
interface iirdf1_in_if
  import iirdf1_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic [CMD_W-1:0]               cmd;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic [IDX_W-1:0]               coef_index;
  logic signed [COEF_W-1:0]       coef_value;

  modport source (output valid, cmd, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, cmd, sample_in, coef_index, coef_value, output ready);
endinterface

interface iirdf1_out_if
  import iirdf1_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           saturated;

  modport source (output valid, sample_out, saturated, input ready);
  modport sink   (input valid, sample_out, saturated, output ready);
endinterface

interface iirdf1_cfg_if
  import iirdf1_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/iirdf1_ctrl.sv
`include "iir_direct_form_one_filter_core_assert.svh"

module iirdf1_ctrl
  import iirdf1_pkg::*;
#(
  parameter int unsigned MAX_ORDER = DEF_MAX_ORDER,
  localparam int unsigned TAP_W    = $clog2(MAX_ORDER + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CMD_W-1:0] in_cmd_i,
  input  logic             filter_enable_i,
  input  logic [TAP_W-1:0] order_n_i,
  input  iirdf1_sts_t      sts_i,
  output iirdf1_cmd_t      cmd_o,
  output logic [TAP_W-1:0] tap_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [TAP_W-1:0] tap_q, tap_d;
  logic             fb_q, fb_d;
  logic             pass_q, pass_d;

  always_comb begin
    state_d    = state_q;
    tap_d      = tap_q;
    fb_d       = fb_q;
    pass_d     = pass_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_cmd_i)
            CMD_SAMPLE: begin
              cmd_o.load_x = 1'b1;
              tap_d        = '0;
              fb_d         = 1'b0;
              pass_d       = !filter_enable_i;
              state_d      = filter_enable_i ? ST_MAC : ST_DONE;
            end
            CMD_WR_FF: cmd_o.wr_ff = 1'b1;
            CMD_WR_FB: cmd_o.wr_fb = 1'b1;
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd_o.mac_en = 1'b1;
        cmd_o.first  = (tap_q == '0);
        cmd_o.sel_fb = fb_q;
        if (tap_q == '0) begin
          tap_d = TAP_W'(1);
        end else if (!fb_q) begin
          fb_d = 1'b1;
        end else if (tap_q == order_n_i) begin
          state_d = ST_DRAIN;
        end else begin
          tap_d = tap_q + TAP_W'(1);
          fb_d  = 1'b0;
        end
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        cmd_o.pass = pass_q;
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign tap_o = tap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q   <= '0;
      fb_q    <= 1'b0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      fb_q    <= fb_d;
      pass_q  <= pass_d;
    end
  end

  `IIRDF1_ASSERT(a_commit_needs_room, cmd_o.commit |-> sts_i.out_free,
                 "result committed while output register is occupied")
  `IIRDF1_ASSERT(a_tap_in_order, (state_q == ST_MAC) |-> (tap_q <= order_n_i),
                 "tap index beyond the order in use")
  `IIRDF1_ASSERT(a_fb_not_tap0, (state_q == ST_MAC && fb_q) |-> (tap_q != '0),
                 "feedback term issued for tap zero")
  `IIRDF1_ASSERT(a_drain_to_done, (state_q == ST_DRAIN) |=> (state_q == ST_DONE),
                 "drain cycle not followed by result cycle")
  `IIRDF1_ASSERT_ALWAYS(a_ready_only_idle, in_ready_o |-> (state_q == ST_IDLE),
                        "request taken outside idle")

endmodule

FILE: rtl/iirdf1_dp.sv
module iirdf1_dp
  import iirdf1_pkg::*;
#(
  parameter int unsigned MAX_ORDER      = DEF_MAX_ORDER,
  parameter int unsigned SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int unsigned COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  localparam int unsigned TAP_W         = $clog2(MAX_ORDER + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  iirdf1_cmd_t                    cmd_i,
  input  logic [TAP_W-1:0]               tap_i,
  output iirdf1_sts_t                    sts_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic [IDX_W-1:0]               coef_index_i,
  input  logic signed [COEF_W-1:0]       coef_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                           saturated_o
);

  localparam int unsigned PROD_W = COEF_W + SAMPLE_WIDTH;
  localparam int unsigned ACC_W  = PROD_W + $clog2(2 * MAX_ORDER + 1);

  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SMAX =
    ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

  logic signed [COEF_W-1:0]       ff_coef_q [0:MAX_ORDER];
  logic signed [COEF_W-1:0]       fb_coef_q [1:MAX_ORDER];
  logic signed [SAMPLE_WIDTH-1:0] xh_q      [1:MAX_ORDER];
  logic signed [SAMPLE_WIDTH-1:0] yh_q      [1:MAX_ORDER];
  logic signed [SAMPLE_WIDTH-1:0] x_q;

  logic signed [COEF_W-1:0]       coef_sel;
  logic signed [SAMPLE_WIDTH-1:0] data_sel;
  logic signed [PROD_W-1:0]       prod_d, prod_q;
  logic                           prod_v_q, prod_first_q, prod_neg_q;
  logic signed [ACC_W-1:0]        prod_ext, acc_base, acc_q;
  logic signed [ACC_W-1:0]        acc_rnd, acc_shr;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic                           y_clip;

  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
  logic                           saturated_q;

  // Coefficient stores, cleared at reset; out-of-range indexes write nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= MAX_ORDER; k++) ff_coef_q[k] <= '0;
      for (int k = 1; k <= MAX_ORDER; k++) fb_coef_q[k] <= '0;
    end else begin
      for (int k = 0; k <= MAX_ORDER; k++) begin
        if (cmd_i.wr_ff && (32'(coef_index_i) == k)) ff_coef_q[k] <= coef_value_i;
      end
      for (int k = 1; k <= MAX_ORDER; k++) begin
        if (cmd_i.wr_fb && (32'(coef_index_i) == k)) fb_coef_q[k] <= coef_value_i;
      end
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    if (tap_i == '0) begin
      coef_sel = ff_coef_q[0];
      data_sel = x_q;
    end else if (cmd_i.sel_fb) begin
      coef_sel = fb_coef_q[tap_i];
      data_sel = yh_q[tap_i];
    end else begin
      coef_sel = ff_coef_q[tap_i];
      data_sel = xh_q[tap_i];
    end
  end

  assign prod_d   = PROD_W'(coef_sel) * PROD_W'(data_sel);
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign acc_base = prod_first_q ? '0 : acc_q;

  // Round half up, then clip to the sample range.
  assign acc_rnd = acc_q + ROUND_HALF;
  assign acc_shr = acc_rnd >>> COEF_FRAC_BITS;

  always_comb begin
    y_clip = 1'b1;
    if (acc_shr > SMAX) begin
      y_sat = SMAX[SAMPLE_WIDTH-1:0];
    end else if (acc_shr < SMIN) begin
      y_sat = SMIN[SAMPLE_WIDTH-1:0];
    end else begin
      y_sat  = acc_shr[SAMPLE_WIDTH-1:0];
      y_clip = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= cmd_i.mac_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) x_q <= sample_in_i;
    if (cmd_i.mac_en) begin
      prod_q       <= prod_d;
      prod_first_q <= cmd_i.first;
      prod_neg_q   <= cmd_i.sel_fb;
    end
    if (prod_v_q) begin
      acc_q <= prod_neg_q ? (acc_base - prod_ext) : (acc_base + prod_ext);
    end
  end

  // Histories, cleared at reset and shifted on every filtered sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= MAX_ORDER; k++) begin
        xh_q[k] <= '0;
        yh_q[k] <= '0;
      end
    end else if (cmd_i.commit && !cmd_i.pass) begin
      xh_q[1] <= x_q;
      yh_q[1] <= y_sat;
      for (int k = 2; k <= MAX_ORDER; k++) begin
        xh_q[k] <= xh_q[k-1];
        yh_q[k] <= yh_q[k-1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      sample_out_q <= cmd_i.pass ? x_q : y_sat;
      saturated_q  <= cmd_i.pass ? 1'b0 : y_clip;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = sample_out_q;
  assign saturated_o    = saturated_q;

endmodule

FILE: rtl/iir_direct_form_one_filter_core.sv
// Channel  | Modport | Payload                                  | Moves
// ---------+---------+------------------------------------------+---------------------------
// in_i     | sink    | cmd, sample_in, coef_index, coef_value   | one request per command
// out_o    | source  | sample_out, saturated                    | one result per sample
// cfg_i    | sink    | index, data                              | one register write
//
// A filtered sample runs tap 0, then a feedforward and a feedback term for each tap up to
// N, the order in use, through the single shared multiplier and its product register; a
// bypassed sample skips the multiplier, and coefficient writes give no result. Reset is
// asynchronous and active low; it clears the histories, coefficients and control registers.
// The next request is taken while a result waits in the output register; a result that
// finds the output register still occupied holds the block until the sink takes it.

module iir_direct_form_one_filter_core
  import iirdf1_pkg::*;
#(
  parameter int unsigned MAX_ORDER      = DEF_MAX_ORDER,
  parameter int unsigned SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int unsigned COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input logic          clk_i,
  input logic          rst_ni,
  iirdf1_in_if.sink    in_i,
  iirdf1_out_if.source out_o,
  iirdf1_cfg_if.sink   cfg_i
);

  localparam int unsigned TAP_W = $clog2(MAX_ORDER + 1);

  logic               filter_enable_q;
  logic [ORDER_W-1:0] order_in_use_q;
  logic [TAP_W-1:0]   order_n;
  logic [TAP_W-1:0]   tap;
  iirdf1_cmd_t        cmd;
  iirdf1_sts_t        sts;

  // Configuration registers. Writes are always taken; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_enable_q <= 1'b0;
      order_in_use_q  <= ORDER_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_FILTER_ENABLE) filter_enable_q <= cfg_i.data[0];
      if (cfg_i.index == REG_ORDER_IN_USE)  order_in_use_q  <= cfg_i.data[ORDER_W-1:0];
    end
  end

  // The order in use is clamped: zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    if (order_in_use_q == '0) begin
      order_n = TAP_W'(1);
    end else if (32'(order_in_use_q) > MAX_ORDER) begin
      order_n = TAP_W'(MAX_ORDER);
    end else begin
      order_n = TAP_W'(order_in_use_q);
    end
  end

  // The controller sequences the taps; the datapath holds the coefficient and history stores and the multiplier.
  iirdf1_ctrl #(
    .MAX_ORDER (MAX_ORDER)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .in_cmd_i        (in_i.cmd),
    .filter_enable_i (filter_enable_q),
    .order_n_i       (order_n),
    .sts_i           (sts),
    .cmd_o           (cmd),
    .tap_o           (tap)
  );

  iirdf1_dp #(
    .MAX_ORDER      (MAX_ORDER),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .tap_i        (tap),
    .sts_o        (sts),
    .sample_in_i  (in_i.sample_in),
    .coef_index_i (in_i.coef_index),
    .coef_value_i (in_i.coef_value),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .sample_out_o (out_o.sample_out),
    .saturated_o  (out_o.saturated)
  );

endmodule

FILE: tb/sv/iirdf1_response_checker.sv
module iirdf1_response_checker
  import iirdf1_pkg::*;
#(
  parameter int unsigned MAX_ORDER      = DEF_MAX_ORDER,
  parameter int unsigned SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int unsigned COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  iirdf1_in_if        in_mon,
  iirdf1_out_if       out_mon,
  iirdf1_cfg_if       cfg_mon,
  output int unsigned pending_o,
  output int unsigned errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SAT_MAX    = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam longint SAT_MIN    = -SAT_MAX - 1;
  localparam longint ROUND_HALF = longint'(1) <<< (COEF_FRAC_BITS - 1);

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           saturated;
  } filter_result_t;

  filter_result_t expected_results[$];

  logic                           filter_on;
  logic [ORDER_W-1:0]             order_sel;
  logic signed [SAMPLE_WIDTH-1:0] x_hist [MAX_ORDER+1];
  logic signed [SAMPLE_WIDTH-1:0] y_hist [MAX_ORDER];
  logic signed [COEF_W-1:0]       b_coef [MAX_ORDER+1];
  logic signed [COEF_W-1:0]       a_coef [MAX_ORDER];
  int unsigned                    err_cnt = 0;

  // Computes one output sample and advances both delay lines when filtering.
  function automatic filter_result_t filter_sample(logic signed [SAMPLE_WIDTH-1:0] x);
    filter_result_t res;
    longint         acc;
    longint         y;
    int unsigned    taps;
    int             i;
    res.sample_out = x;
    res.saturated  = 1'b0;
    if (!filter_on) begin
      return res;
    end
    taps = order_sel;
    if (taps < 1) taps = 1;
    if (taps > MAX_ORDER) taps = MAX_ORDER;
    acc = longint'(b_coef[0]) * longint'(x);
    for (i = 1; i <= int'(taps); i++) begin
      acc += longint'(b_coef[i]) * longint'(x_hist[i-1]);
      acc -= longint'(a_coef[i-1]) * longint'(y_hist[i-1]);
    end
    y = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;
    if (y > SAT_MAX) begin
      y = SAT_MAX;
      res.saturated = 1'b1;
    end else if (y < SAT_MIN) begin
      y = SAT_MIN;
      res.saturated = 1'b1;
    end
    for (i = MAX_ORDER; i > 0; i--) begin
      x_hist[i] = x_hist[i-1];
    end
    x_hist[0] = x;
    for (i = MAX_ORDER - 1; i > 0; i--) begin
      y_hist[i] = y_hist[i-1];
    end
    y_hist[0] = y[SAMPLE_WIDTH-1:0];
    res.sample_out = y[SAMPLE_WIDTH-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filter_result_t exp_res;
    if (!rst_ni) begin
      filter_on = 1'b0;
      order_sel = ORDER_RESET;
      for (int k = 0; k <= MAX_ORDER; k++) begin
        x_hist[k] = '0;
        b_coef[k] = '0;
      end
      for (int k = 0; k < MAX_ORDER; k++) begin
        y_hist[k] = '0;
        a_coef[k] = '0;
      end
      expected_results.delete();
    end else begin
      // Results are checked before new requests are predicted; a new sample
      // can never produce its result in the cycle it is accepted.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: sample_out %0d saturated %0b",
                 out_mon.sample_out, out_mon.saturated);
          err_cnt++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_mon.sample_out !== exp_res.sample_out) begin
            $error("sample_out mismatch: expected %0d, actual %0d",
                   exp_res.sample_out, out_mon.sample_out);
            err_cnt++;
          end
          if (out_mon.saturated !== exp_res.saturated) begin
            $error("saturated mismatch: expected %0b, actual %0b",
                   exp_res.saturated, out_mon.saturated);
            err_cnt++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_FILTER_ENABLE: filter_on = cfg_mon.data[0];
          REG_ORDER_IN_USE:  order_sel = cfg_mon.data[ORDER_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.cmd)
          CMD_WR_FF: begin
            if (in_mon.coef_index <= MAX_ORDER) b_coef[in_mon.coef_index] = in_mon.coef_value;
          end
          CMD_WR_FB: begin
            if (in_mon.coef_index >= 1 && in_mon.coef_index <= MAX_ORDER)
              a_coef[in_mon.coef_index - 1] = in_mon.coef_value;
          end
          CMD_SAMPLE: begin
            expected_results.insert(expected_results.size(), filter_sample(in_mon.sample_in));
          end
          default: ;
        endcase
      end
    end
    pending_o = expected_results.size();
    errors_o  = err_cnt;
  end

endmodule

FILE: tb/sv/iir_direct_form_one_filter_core_tb.sv
module iir_direct_form_one_filter_core_tb
  import iirdf1_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ORDER      = DEF_MAX_ORDER;
  localparam int unsigned SAMPLE_W       = DEF_SAMPLE_WIDTH;
  localparam int unsigned COEF_FRAC_BITS = DEF_COEF_FRAC_BITS;

  // Codes the package leaves unnamed; the block must ignore them.
  localparam logic [CMD_W-1:0]     CMD_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // The settle pause outlasts the worst sample at the largest order with margin,
  // so that no coefficient write is still in flight.
  localparam int unsigned SETTLE_CYCLES = 2 * MAX_ORDER + 12;
  localparam int unsigned SEG_ITEMS     = 100;
  localparam int unsigned SEGS_PER_PHASE = 6;
  localparam int unsigned SEGMENTS      = 3 * SEGS_PER_PHASE;
  localparam int unsigned HOLD_CYCLES   = 500;
  localparam int unsigned CYCLE_LIMIT   = 500000;

  logic clk_i;
  logic rst_ni;

  iirdf1_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) in_bus ();
  iirdf1_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) out_bus ();
  iirdf1_cfg_if                            cfg_bus ();

  int unsigned pending_results;
  int unsigned error_count;

  // Idle percentages of the sender and the receiver for the current phase.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned phase_sel;
  logic        hold_rx;

  iir_direct_form_one_filter_core #(
    .MAX_ORDER      (MAX_ORDER),
    .SAMPLE_WIDTH   (SAMPLE_W),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  iirdf1_response_checker #(
    .MAX_ORDER      (MAX_ORDER),
    .SAMPLE_WIDTH   (SAMPLE_W),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_bus),
    .out_mon   (out_bus),
    .cfg_mon   (cfg_bus),
    .pending_o (pending_results),
    .errors_o  (error_count)
  );

  // A 2 ns clock that starts low, so the first rising edge falls at 1 ns.
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // The receiver is ready at random according to the phase, and not at all
  // while a hold-off stretch is running. It changes only at falling edges.
  always @(negedge clk_i) begin
    out_bus.ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
  end

  // One long hold-off of the receiver early in the phase without idling. The
  // sender keeps offering requests, so the output register and then the input
  // side of the block fill up and stall. Counted on rising edges and read on
  // falling edges, so there is no race with the ready process.
  initial begin
    hold_rx = 1'b0;
    wait (phase_sel == 2);
    repeat (40) @(posedge clk_i);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  // The run is ended as a failure if it has not finished by the cycle limit.
  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Phase 0 lets the sender idle less than the receiver, phase 1 swaps them,
  // and phase 2 has no idling on either side.
  task automatic set_phase(int unsigned p);
    phase_sel = p;
    case (p)
      0: begin
        send_idle_pct = 27;
        recv_idle_pct = 52;
      end
      1: begin
        send_idle_pct = 52;
        recv_idle_pct = 27;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Offers one request and returns at the rising edge where it is accepted.
  // Valid is assigned once per falling edge, so back-to-back requests keep it
  // high without a glitch.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic signed [SAMPLE_W-1:0] sample,
                              logic [IDX_W-1:0] idx, logic signed [COEF_W-1:0] value);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.cmd        <= cmd;
    in_bus.sample_in  <= sample;
    in_bus.coef_index <= idx;
    in_bus.coef_value <= value;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  // Register writes are issued only while the block is idle.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
    end
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Drops the request valid, waits for every predicted result, then lets the
  // block finish any coefficient write that gives no result.
  task automatic wait_idle();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Uniform coefficient in [-2^mag, 2^mag - 1].
  function automatic logic signed [COEF_W-1:0] rand_coef(int unsigned mag);
    int span;
    span = 1 << mag;
    return COEF_W'(int'($urandom_range(2 * span - 1)) - span);
  endfunction

  // Mostly uniform samples, with the extremes and values near zero mixed in.
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] s;
    s = SAMPLE_W'($urandom_range(65535));
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(4))
        0: s = 16'sh7FFF;
        1: s = 16'sh8000;
        2: s = 16'sh0000;
        3: s = 16'sh0001;
        default: s = 16'shFFFF;
      endcase
    end
    return s;
  endfunction

  initial begin : stimulus
    int unsigned                counted;
    int unsigned                r;
    logic [CMD_W-1:0]           wr_cmd;
    logic signed [COEF_W-1:0]   wr_val;
    logic [CFG_DATA_W-1:0]      cfg_data;

    // Every input of the block is known from time zero.
    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.cmd         = CMD_SAMPLE;
    in_bus.sample_in   = '0;
    in_bus.coef_index  = '0;
    in_bus.coef_value  = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = REG_FILTER_ENABLE;
    cfg_bus.data       = '0;
    out_bus.ready      = 1'b0;
    set_phase(0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. After reset the filter is off, so samples pass through.
    send_request(CMD_SAMPLE, 16'sh7FFF, '0, '0);
    send_request(CMD_SAMPLE, 16'sh8000, '0, '0);
    wait_idle();
    // Upper data bits are set to show that only the register width counts.
    write_register(REG_FILTER_ENABLE, 8'hFF);
    write_register(REG_ORDER_IN_USE, 8'hFC);
    write_register(REG_SPARE_2, 8'hA5);
    write_register(REG_SPARE_3, 8'h5A);
    // The coefficients are still cleared, so the output is zero.
    send_request(CMD_SAMPLE, 16'sh0064, '0, '0);
    // A unit gain on the current sample.
    send_request(CMD_WR_FF, '0, 3'd0, 24'sh100000);
    send_request(CMD_SAMPLE, 16'sh7FFF, '0, '0);
    // The largest gain clips to both ends of the sample range.
    send_request(CMD_WR_FF, '0, 3'd0, 24'sh7FFFFF);
    send_request(CMD_SAMPLE, 16'sh7FFF, '0, '0);
    send_request(CMD_SAMPLE, 16'sh8000, '0, '0);
    // A gain of one half hits the rounding halfway point from both sides.
    send_request(CMD_WR_FF, '0, 3'd0, 24'sh080000);
    send_request(CMD_SAMPLE, 16'sh0001, '0, '0);
    send_request(CMD_SAMPLE, 16'shFFFF, '0, '0);
    send_request(CMD_SAMPLE, 16'sh0003, '0, '0);
    // Out-of-range tap indexes and the unused command must change nothing.
    send_request(CMD_WR_FF, '0, 3'd5, 24'sh7FFFFF);
    send_request(CMD_WR_FF, '0, 3'd7, 24'sh800000);
    send_request(CMD_WR_FB, '0, 3'd0, 24'sh7FFFFF);
    send_request(CMD_WR_FB, '0, 3'd6, 24'sh800000);
    send_request(CMD_UNUSED, 16'sh1234, 3'd1, 24'sh7FFFFF);
    // The most negative feedback makes the output grow from its history.
    send_request(CMD_WR_FB, '0, 3'd1, 24'sh800000);
    send_request(CMD_SAMPLE, 16'sh0000, '0, '0);
    // The far taps at their extremes, driven with full-scale samples.
    send_request(CMD_WR_FF, '0, 3'd4, 24'sh800000);
    send_request(CMD_WR_FB, '0, 3'd4, 24'sh7FFFFF);
    send_request(CMD_SAMPLE, 16'sh8000, '0, '0);
    send_request(CMD_SAMPLE, 16'sh7FFF, '0, '0);
    send_request(CMD_SAMPLE, 16'sh8000, '0, '0);

    // Random part, in segments. Each segment starts from an idle block with a
    // new setting: every order code 0 to 7 comes up, and one segment in six
    // runs with the filter off. A full coefficient load follows, so most
    // samples go through a well-formed filter with random taps; stray
    // coefficient writes and unused commands are mixed in as noise.
    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      set_phase(seg / SEGS_PER_PHASE);
      cfg_data = {7'($urandom_range(127)), (seg % 6 != 5)};
      write_register(REG_FILTER_ENABLE, cfg_data);
      cfg_data = {5'($urandom_range(31)), 3'(seg % 8)};
      write_register(REG_ORDER_IN_USE, cfg_data);
      counted = 0;
      for (int unsigned t = 0; t <= MAX_ORDER; t++) begin
        wr_val = ($urandom_range(7) == 0) ? rand_coef(23) : rand_coef(20);
        send_request(CMD_WR_FF, rand_sample(), IDX_W'(t), wr_val);
        counted++;
      end
      // Feedback taps stay small most of the time so the loop stays stable.
      for (int unsigned t = 1; t <= MAX_ORDER; t++) begin
        wr_val = ($urandom_range(7) == 0) ? rand_coef(23) : rand_coef(18);
        send_request(CMD_WR_FB, rand_sample(), IDX_W'(t), wr_val);
        counted++;
      end
      while (counted < SEG_ITEMS) begin
        r = $urandom_range(99);
        if (r < 85) begin
          send_request(CMD_SAMPLE, rand_sample(), IDX_W'($urandom_range(7)),
                       rand_coef(23));
          counted++;
        end else if (r < 93) begin
          wr_cmd = ($urandom_range(1) == 0) ? CMD_WR_FF : CMD_WR_FB;
          wr_val = ($urandom_range(1) == 0) ? rand_coef(23) : rand_coef(18);
          send_request(wr_cmd, rand_sample(), IDX_W'($urandom_range(7)), wr_val);
          counted++;
        end else begin
          send_request(CMD_UNUSED, rand_sample(), IDX_W'($urandom_range(7)),
                       rand_coef(23));
        end
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/iirdf1_pkg.sv
rtl/iirdf1_if.sv
rtl/iirdf1_ctrl.sv
rtl/iirdf1_dp.sv
rtl/iir_direct_form_one_filter_core.sv
tb/sv/iirdf1_response_checker.sv
tb/sv/iir_direct_form_one_filter_core_tb.sv
